// File: design/i2cme_pkg.sv
// i2cme_pkg: shared types, command codes, register indexes and phase codes of the
// I2C master byte engine. Used by i2cme_core and i2c_master_byte_engine; depends on nothing.
package i2cme_pkg;

    localparam int DelayW = 16;
    localparam int TimeoutW = 8;
    localparam int ModeW = 4;
    localparam int ByteW = 8;
    localparam int BitCntW = 4;
    localparam int InW = 16;
    localparam int OutW = 16;

    localparam logic [DelayW-1:0]   DELAY_RESET = 16'd100;
    localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 8'd250;
    localparam logic [BitCntW-1:0]  BITS_PER_BYTE = 4'd8;

    localparam logic CFG_DELAY = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [ModeW-1:0] CMD_START = 4'd0;
    localparam logic [ModeW-1:0] CMD_STOP = 4'd1;
    localparam logic [ModeW-1:0] CMD_SEND = 4'd2;
    localparam logic [ModeW-1:0] CMD_WAIT_ACK = 4'd3;
    localparam logic [ModeW-1:0] CMD_READ_ACK = 4'd4;
    localparam logic [ModeW-1:0] CMD_READ_NACK = 4'd5;
    localparam logic [ModeW-1:0] CMD_ACK = 4'd6;
    localparam logic [ModeW-1:0] CMD_NACK = 4'd7;
    localparam logic [ModeW-1:0] CMD_CLEAR = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_ST_C    = 5'd3,
        PH_SP_A    = 5'd4,
        PH_SP_B    = 5'd5,
        PH_SP_C    = 5'd6,
        PH_TX_LO   = 5'd7,
        PH_TX_HI   = 5'd8,
        PH_WA_REL  = 5'd9,
        PH_WA_CLK  = 5'd10,
        PH_WA_POLL = 5'd11,
        PH_WA_END  = 5'd12,
        PH_TO_A    = 5'd13,
        PH_TO_B    = 5'd14,
        PH_TO_C    = 5'd15,
        PH_RX_HI   = 5'd16,
        PH_RX_LO   = 5'd17,
        PH_AK_SDA  = 5'd18,
        PH_AK_HI   = 5'd19,
        PH_AK_LO   = 5'd20,
        PH_AK_REL  = 5'd21
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [ModeW-1:0]    command_held;
        logic [BitCntW-1:0]  bit_count;
        logic [ByteW-1:0]    shift_reg;
        logic [DelayW-1:0]   delay_count;
        logic [TimeoutW-1:0] poll_count;
        logic                scl_level;
        logic                sda_level;
        logic                sticky_error;
        logic                last_ack_missing;
        logic [ByteW-1:0]    read_byte;
    } eng_state_t;

    typedef struct packed {
        logic             cmd_valid;
        logic [ModeW-1:0] mode;
        logic [ByteW-1:0] write_byte;
        logic             sda_in;
    } tick_in_t;

endpackage

// File: design/i2c_master_byte_engine.sv
// i2c_master_byte_engine: I2C master that moves one bus tick per input word.
// Depends on i2cme_pkg and i2cme_core.
//
//  port group  | dir | word contents
//  s_*         | in  | one bus tick: command offer, mode, byte to send, sampled SDA
//  m_*         | out | line levels and status after that tick
//  cfg_*       | in  | register writes: 0 delay_ticks, 1 ack_timeout
//
// One input word is taken per cycle unless a stalled result holds acceptance; its result
// word is registered at the same edge and offered from the next cycle.
// The engine state and the result register update together on each accepted word.
// A stalled result holds input acceptance only while the result register is full.
// Reset clears the engine to idle with both lines released.
module i2c_master_byte_engine
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [0] cmd_valid, [4:1] mode, [12:5] write_byte, [13] sda_in, [15:14] unused
    input  logic [i2cme_pkg::InW-1:0]        s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] ack_missing, [13] error_flag, [15:14] zero
    output logic [i2cme_pkg::OutW-1:0]       m_tdata,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [i2cme_pkg::DelayW-1:0]     cfg_wdata
);

    i2cme_pkg::eng_state_t state_reg;
    i2cme_pkg::eng_state_t state_next;
    i2cme_pkg::tick_in_t tick;
    logic [i2cme_pkg::DelayW-1:0] delay_ticks_reg;
    logic [i2cme_pkg::TimeoutW-1:0] ack_timeout_reg;
    logic m_tvalid_reg;
    logic [i2cme_pkg::OutW-1:0] m_tdata_reg;
    logic done;
    logic accept;

    assign tick.cmd_valid = s_tdata[0];
    assign tick.mode = s_tdata[4:1];
    assign tick.write_byte = s_tdata[12:5];
    assign tick.sda_in = s_tdata[13];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    i2cme_core u_core
    (
        .cur         (state_reg),
        .tick        (tick),
        .delay_ticks (delay_ticks_reg),
        .ack_timeout (ack_timeout_reg),
        .nxt         (state_next),
        .done        (done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= i2cme_pkg::DELAY_RESET;
            ack_timeout_reg <= i2cme_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cme_pkg::CFG_DELAY:   delay_ticks_reg <= cfg_wdata;
                i2cme_pkg::CFG_TIMEOUT: ack_timeout_reg <= cfg_wdata[i2cme_pkg::TimeoutW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: i2cme_pkg::PH_IDLE, scl_level: 1'b1, sda_level: 1'b1,
                           default: '0};
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {2'b00, state_next.sticky_error, state_next.last_ack_missing,
                            state_next.read_byte, done,
                            state_next.phase != i2cme_pkg::PH_IDLE,
                            state_next.sda_level, state_next.scl_level};
        end
    end

`ifndef SYNTHESIS
    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted word produced no result");
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done and busy in the same word");
    a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == i2cme_pkg::PH_IDLE |-> state_reg.delay_count == '0)
        else $error("delay count left running in idle");
    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_count <= i2cme_pkg::BITS_PER_BYTE)
        else $error("bit count past one byte");
`endif

endmodule

// File: design/i2cme_core.sv
// i2cme_core: next-state logic of the bus-timing engine for one tick.
// Depends on i2cme_pkg.
module i2cme_core
(
    input  i2cme_pkg::eng_state_t        cur,
    input  i2cme_pkg::tick_in_t          tick,
    input  logic [i2cme_pkg::DelayW-1:0]   delay_ticks,
    input  logic [i2cme_pkg::TimeoutW-1:0] ack_timeout,
    output i2cme_pkg::eng_state_t        nxt,
    output logic                         done
);

    i2cme_pkg::phase_t ent_ph;
    logic ent_en;
    logic fin;
    logic wants_ack;
    logic [i2cme_pkg::DelayW-1:0] dly_dec;

    always_comb
    begin
        nxt = cur;
        ent_en = 1'b0;
        ent_ph = i2cme_pkg::PH_IDLE;
        fin = 1'b0;
        done = 1'b0;
        dly_dec = cur.delay_count;

        if (cur.phase == i2cme_pkg::PH_IDLE)
        begin
            if (tick.cmd_valid && tick.mode <= i2cme_pkg::CMD_CLEAR)
            begin
                nxt.command_held = tick.mode;
                nxt.bit_count = '0;
                case (tick.mode)
                    i2cme_pkg::CMD_START:
                    begin
                        ent_en = 1'b1;
                        ent_ph = i2cme_pkg::PH_ST_A;
                    end
                    i2cme_pkg::CMD_STOP:
                    begin
                        ent_en = 1'b1;
                        ent_ph = i2cme_pkg::PH_SP_A;
                    end
                    i2cme_pkg::CMD_SEND:
                    begin
                        nxt.shift_reg = tick.write_byte;
                        ent_en = 1'b1;
                        ent_ph = i2cme_pkg::PH_TX_LO;
                    end
                    i2cme_pkg::CMD_WAIT_ACK:
                    begin
                        ent_en = 1'b1;
                        ent_ph = i2cme_pkg::PH_WA_REL;
                    end
                    i2cme_pkg::CMD_READ_ACK, i2cme_pkg::CMD_READ_NACK:
                    begin
                        nxt.shift_reg = '0;
                        ent_en = 1'b1;
                        ent_ph = i2cme_pkg::PH_RX_HI;
                    end
                    i2cme_pkg::CMD_ACK, i2cme_pkg::CMD_NACK:
                    begin
                        ent_en = 1'b1;
                        ent_ph = i2cme_pkg::PH_AK_SDA;
                    end
                    default:
                    begin
                        nxt.sticky_error = 1'b0;
                        nxt.last_ack_missing = 1'b0;
                        done = 1'b1;
                    end
                endcase
            end
        end
        else if (cur.phase == i2cme_pkg::PH_WA_POLL)
        begin
            if (!tick.sda_in)
            begin
                nxt.last_ack_missing = 1'b0;
                ent_en = 1'b1;
                ent_ph = i2cme_pkg::PH_WA_END;
            end
            else if (cur.poll_count >= ack_timeout)
            begin
                nxt.last_ack_missing = 1'b1;
                nxt.sticky_error = 1'b1;
                ent_en = 1'b1;
                ent_ph = i2cme_pkg::PH_TO_A;
            end
            else
            begin
                nxt.poll_count = cur.poll_count + 1'b1;
            end
        end
        else
        begin
            if (cur.delay_count != '0)
            begin
                dly_dec = cur.delay_count - 1'b1;
            end
            nxt.delay_count = dly_dec;
            if (dly_dec == '0)
            begin
                case (cur.phase)
                    i2cme_pkg::PH_ST_A:   begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_ST_B; end
                    i2cme_pkg::PH_ST_B:   begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_ST_C; end
                    i2cme_pkg::PH_SP_A:   begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_SP_B; end
                    i2cme_pkg::PH_SP_B:   begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_SP_C; end
                    i2cme_pkg::PH_TX_LO:  begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_TX_HI; end
                    i2cme_pkg::PH_TX_HI:
                    begin
                        nxt.bit_count = cur.bit_count + 1'b1;
                        nxt.shift_reg = {cur.shift_reg[i2cme_pkg::ByteW-2:0], 1'b0};
                        if (nxt.bit_count >= i2cme_pkg::BITS_PER_BYTE)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            ent_en = 1'b1;
                            ent_ph = i2cme_pkg::PH_TX_LO;
                        end
                    end
                    i2cme_pkg::PH_WA_REL: begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_WA_CLK; end
                    i2cme_pkg::PH_WA_CLK: begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_WA_POLL; end
                    i2cme_pkg::PH_TO_A:   begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_TO_B; end
                    i2cme_pkg::PH_TO_B:   begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_TO_C; end
                    i2cme_pkg::PH_TO_C:   begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_WA_END; end
                    i2cme_pkg::PH_RX_HI:
                    begin
                        nxt.shift_reg = {cur.shift_reg[i2cme_pkg::ByteW-2:0], tick.sda_in};
                        nxt.bit_count = cur.bit_count + 1'b1;
                        ent_en = 1'b1;
                        ent_ph = i2cme_pkg::PH_RX_LO;
                    end
                    i2cme_pkg::PH_RX_LO:
                    begin
                        ent_en = 1'b1;
                        if (cur.bit_count >= i2cme_pkg::BITS_PER_BYTE)
                        begin
                            nxt.read_byte = cur.shift_reg;
                            ent_ph = i2cme_pkg::PH_AK_SDA;
                        end
                        else
                        begin
                            ent_ph = i2cme_pkg::PH_RX_HI;
                        end
                    end
                    i2cme_pkg::PH_AK_SDA: begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_AK_HI; end
                    i2cme_pkg::PH_AK_HI:  begin ent_en = 1'b1; ent_ph = i2cme_pkg::PH_AK_LO; end
                    i2cme_pkg::PH_AK_LO:
                    begin
                        if (cur.command_held == i2cme_pkg::CMD_READ_ACK
                            || cur.command_held == i2cme_pkg::CMD_ACK)
                        begin
                            ent_en = 1'b1;
                            ent_ph = i2cme_pkg::PH_AK_REL;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    default: fin = 1'b1;
                endcase
            end
        end

        wants_ack = (nxt.command_held == i2cme_pkg::CMD_READ_ACK)
            || (nxt.command_held == i2cme_pkg::CMD_ACK);

        if (ent_en)
        begin
            nxt.phase = ent_ph;
            nxt.delay_count = (delay_ticks == '0) ? 16'd1 : delay_ticks;
            case (ent_ph)
                i2cme_pkg::PH_ST_A:
                begin
                    nxt.sda_level = 1'b1;
                    nxt.scl_level = 1'b1;
                end
                i2cme_pkg::PH_ST_B: nxt.sda_level = 1'b0;
                i2cme_pkg::PH_ST_C: nxt.scl_level = 1'b0;
                i2cme_pkg::PH_SP_A, i2cme_pkg::PH_TO_A: nxt.sda_level = 1'b0;
                i2cme_pkg::PH_SP_B, i2cme_pkg::PH_TO_B: nxt.scl_level = 1'b1;
                i2cme_pkg::PH_SP_C, i2cme_pkg::PH_TO_C: nxt.sda_level = 1'b1;
                i2cme_pkg::PH_TX_LO:
                begin
                    if (nxt.bit_count != '0)
                    begin
                        nxt.scl_level = 1'b0;
                    end
                    nxt.sda_level = nxt.shift_reg[i2cme_pkg::ByteW-1];
                end
                i2cme_pkg::PH_TX_HI:   nxt.scl_level = 1'b1;
                i2cme_pkg::PH_WA_REL:  nxt.sda_level = 1'b1;
                i2cme_pkg::PH_WA_CLK:  nxt.scl_level = 1'b1;
                i2cme_pkg::PH_WA_POLL: nxt.poll_count = '0;
                i2cme_pkg::PH_WA_END:  nxt.scl_level = 1'b0;
                i2cme_pkg::PH_RX_HI:
                begin
                    nxt.scl_level = 1'b1;
                    if (nxt.bit_count == '0)
                    begin
                        nxt.sda_level = 1'b1;
                    end
                end
                i2cme_pkg::PH_RX_LO:  nxt.scl_level = 1'b0;
                i2cme_pkg::PH_AK_SDA: nxt.sda_level = !wants_ack;
                i2cme_pkg::PH_AK_HI:  nxt.scl_level = 1'b1;
                i2cme_pkg::PH_AK_LO:  nxt.scl_level = 1'b0;
                i2cme_pkg::PH_AK_REL: nxt.sda_level = 1'b1;
                default: ;
            endcase
        end
        else if (fin)
        begin
            if (cur.command_held == i2cme_pkg::CMD_SEND)
            begin
                nxt.scl_level = 1'b0;
                nxt.sda_level = 1'b1;
            end
            nxt.phase = i2cme_pkg::PH_IDLE;
            nxt.delay_count = '0;
            done = 1'b1;
        end
    end

endmodule
